// ----- hw/rtl/tlgp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgp_pkg
// shared types and constants of the scan telegram parser
// ----------------------------------------------------------------------------
package tlgp_pkg;

  // store size per channel and number of header tokens ahead of the encoder count
  localparam int unsigned MAX_SAMPLES   = 2048;
  localparam int unsigned HEADER_TOKENS = 18;

  localparam int unsigned LEN_W  = 12;  // holds 0 .. MAX_SAMPLES
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned TDATA_W = 64;
  localparam int unsigned TUSER_W = 5;

  // result kinds
  typedef enum logic [1:0] {
    RES_SAMPLE   = 2'd0,
    RES_LENGTH   = 2'd1,
    RES_FINISHED = 2'd2
  } res_kind_e;

  // channel codes, unknown names map to CH_UNKNOWN
  localparam logic [2:0] CH_UNKNOWN = 3'd4;

  // channel names, first character in the top byte; index is the channel code
  localparam logic [3:0][39:0] CHAN_NAMES = {"RSSI2", "RSSI1", "DIST2", "DIST1"};

  // characters with a meaning to the parser
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_STX   = 8'h02;
  localparam logic [7:0] CHR_ETX   = 8'h03;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;

  typedef struct packed {
    logic             last;
    logic             trunc;
    logic             clamped;
    logic [LEN_W-1:0] len;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] idx;
    logic             eight;
    logic [1:0]       chan;
    res_kind_e        kind;
  } result_t;

endpackage

// ----- hw/rtl/tlgp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgp_core
// per-byte parse state and the results one byte produces (up to two)
// ----------------------------------------------------------------------------
module tlgp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  output logic [1:0]          res_cnt_o,
  output tlgp_pkg::result_t   res0_o,
  output tlgp_pkg::result_t   res1_o
);

  typedef enum logic [8:0] {
    PH_HEADER    = 9'b000000001,
    PH_ENC_COUNT = 9'b000000010,
    PH_ENC_SKIP  = 9'b000000100,
    PH_CH_COUNT  = 9'b000001000,
    PH_NAME      = 9'b000010000,
    PH_SKIP4     = 9'b000100000,
    PH_NDATA     = 9'b001000000,
    PH_SAMPLES   = 9'b010000000,
    PH_DONE      = 9'b100000000
  } phase_e;

  localparam logic [8:0]  HDR_TOKENS = 9'(tlgp_pkg::HEADER_TOKENS);
  localparam logic [31:0] MAX_S32    = 32'(tlgp_pkg::MAX_SAMPLES);
  localparam logic [tlgp_pkg::LEN_W-1:0] MAX_SL = tlgp_pkg::LEN_W'(tlgp_pkg::MAX_SAMPLES);

  phase_e                    phase_q, phase_d;
  logic [8:0]                tcnt_q, tcnt_d;
  logic                      in_tok_q, in_tok_d;
  logic [31:0]               acc_q, acc_d;
  logic                      sat_q, sat_d;
  logic                      ended_q, ended_d;
  logic [39:0]               name_q, name_d;
  logic [2:0]                nlen_q, nlen_d;
  logic [2:0]                chan_q, chan_d;
  logic                      eight_q, eight_d;
  logic [7:0]                chleft_q, chleft_d;
  logic [tlgp_pkg::LEN_W-1:0] total_q, total_d;
  logic [tlgp_pkg::LEN_W-1:0] scnt_q, scnt_d;
  logic                      clamp_q, clamp_d;
  logic [31:0]               excess_q, excess_d;

  logic                      sep;
  logic                      skip_char;
  logic                      hex_mode;
  logic                      dig_ok;
  logic [3:0]                dig_val;
  logic [35:0]               prod;
  logic                      do_end;
  logic [7:0]                sat8;
  logic                      known;
  logic [2:0]                match;
  logic                      tres_v;
  tlgp_pkg::result_t         tres;
  tlgp_pkg::result_t         fin;

  always_comb begin
    phase_d  = phase_q;
    tcnt_d   = tcnt_q;
    in_tok_d = in_tok_q;
    acc_d    = acc_q;
    sat_d    = sat_q;
    ended_d  = ended_q;
    name_d   = name_q;
    nlen_d   = nlen_q;
    chan_d   = chan_q;
    eight_d  = eight_q;
    chleft_d = chleft_q;
    total_d  = total_q;
    scnt_d   = scnt_q;
    clamp_d  = clamp_q;
    excess_d = excess_q;
    sep       = (in_byte_i == tlgp_pkg::CHR_SPACE) || (in_byte_i == tlgp_pkg::CHR_STX) ||
                (in_byte_i == tlgp_pkg::CHR_ETX);
    skip_char = 1'b0;
    hex_mode  = (phase_q == PH_NDATA) || (phase_q == PH_SAMPLES);
    dig_ok    = 1'b0;
    dig_val   = 4'd0;
    prod      = '0;
    do_end    = 1'b0;
    sat8      = 8'd0;
    known     = 1'b0;
    match     = tlgp_pkg::CH_UNKNOWN;
    tres_v    = 1'b0;
    tres      = '0;
    fin       = '0;
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;

    // digit decode
    if (in_byte_i inside {[8'h30:8'h39]}) begin
      dig_ok  = 1'b1;
      dig_val = in_byte_i[3:0];
    end else if (hex_mode && (in_byte_i inside {[8'h41:8'h46], [8'h61:8'h66]})) begin
      dig_ok  = 1'b1;
      dig_val = in_byte_i[3:0] + 4'd9;
    end

    if (in_valid_i) begin
      // character inside a token
      if (!sep) begin
        if (!in_tok_q) begin
          in_tok_d = 1'b1;
          acc_d    = '0;
          sat_d    = 1'b0;
          ended_d  = 1'b0;
          nlen_d   = '0;
          name_d   = '0;
          if (in_byte_i == tlgp_pkg::CHR_PLUS) skip_char = 1'b1;
        end
        if (!skip_char) begin
          if (phase_q == PH_NAME) begin
            if (nlen_d < 3'd5) begin
              name_d = {name_d[31:0], in_byte_i};
              nlen_d = nlen_d + 3'd1;
            end else begin
              nlen_d = 3'd6;
            end
          end
          if (!ended_d) begin
            if (!dig_ok) begin
              ended_d = 1'b1;
            end else if (!sat_d) begin
              if (hex_mode) prod = {acc_d, dig_val};
              else prod = {1'b0, acc_d, 3'b000} + {3'b000, acc_d, 1'b0} + {32'd0, dig_val};
              if (prod[35:32] != 4'd0) begin
                acc_d = '1;
                sat_d = 1'b1;
              end else begin
                acc_d = prod[31:0];
              end
            end
          end
        end
      end

      do_end = sep ? in_tok_q : in_last_i;
      sat8   = (acc_d[31:8] != 24'd0) ? 8'hFF : acc_d[7:0];
      known  = chan_q != tlgp_pkg::CH_UNKNOWN;
      for (int i = 3; i >= 0; i--) begin
        if (name_d == tlgp_pkg::CHAN_NAMES[i]) match = 3'(i);
      end

      // token finished
      if (do_end) begin
        in_tok_d = 1'b0;
        case (phase_q)
          PH_HEADER: begin
            tcnt_d = tcnt_q + 9'd1;
            if (tcnt_d >= HDR_TOKENS) phase_d = PH_ENC_COUNT;
          end
          PH_ENC_COUNT: begin
            tcnt_d  = {sat8, 1'b0};
            phase_d = (sat8 != 8'd0) ? PH_ENC_SKIP : PH_CH_COUNT;
          end
          PH_ENC_SKIP: begin
            if (tcnt_q != 9'd0) tcnt_d = tcnt_q - 9'd1;
            if (tcnt_d == 9'd0) phase_d = PH_CH_COUNT;
          end
          PH_CH_COUNT: begin
            chleft_d = sat8;
            if (sat8 != 8'd0) begin
              phase_d = PH_NAME;
            end else begin
              phase_d = eight_q ? PH_DONE : PH_CH_COUNT;
              eight_d = 1'b1;
            end
          end
          PH_NAME: begin
            chan_d  = (nlen_d == 3'd5) ? match : tlgp_pkg::CH_UNKNOWN;
            tcnt_d  = 9'd4;
            phase_d = PH_SKIP4;
          end
          PH_SKIP4: begin
            if (tcnt_q != 9'd0) tcnt_d = tcnt_q - 9'd1;
            if (tcnt_d == 9'd0) phase_d = PH_NDATA;
          end
          PH_NDATA: begin
            if (acc_d > MAX_S32) begin
              total_d  = MAX_SL;
              excess_d = acc_d - MAX_S32;
              clamp_d  = 1'b1;
            end else begin
              total_d  = acc_d[tlgp_pkg::LEN_W-1:0];
              excess_d = '0;
            end
            scnt_d       = '0;
            tres_v       = known;
            tres.kind    = tlgp_pkg::RES_LENGTH;
            tres.chan    = chan_q[1:0];
            tres.eight   = eight_q;
            tres.len     = total_d;
            tres.clamped = clamp_d;
            if (acc_d == 32'd0) begin
              if (chleft_q != 8'd0) chleft_d = chleft_q - 8'd1;
              if (chleft_d != 8'd0) begin
                phase_d = PH_NAME;
              end else begin
                phase_d = eight_q ? PH_DONE : PH_CH_COUNT;
                eight_d = 1'b1;
              end
            end else begin
              phase_d = PH_SAMPLES;
            end
          end
          PH_SAMPLES: begin
            if (scnt_q < total_q) begin
              tres_v       = known;
              tres.kind    = tlgp_pkg::RES_SAMPLE;
              tres.chan    = chan_q[1:0];
              tres.eight   = eight_q;
              tres.idx     = scnt_q[tlgp_pkg::IDX_W-1:0];
              tres.value   = acc_d;
              tres.len     = total_q;
              tres.clamped = clamp_q;
              scnt_d       = scnt_q + {{(tlgp_pkg::LEN_W-1){1'b0}}, 1'b1};
            end else if (excess_q != 32'd0) begin
              excess_d = excess_q - 32'd1;
            end
            if ((scnt_d >= total_q) && (excess_d == 32'd0)) begin
              if (chleft_q != 8'd0) chleft_d = chleft_q - 8'd1;
              if (chleft_d != 8'd0) begin
                phase_d = PH_NAME;
              end else begin
                phase_d = eight_q ? PH_DONE : PH_CH_COUNT;
                eight_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end

      // results of the byte: the token result, and at telegram end the finished result and a return to the reset state
      fin.kind    = tlgp_pkg::RES_FINISHED;
      fin.clamped = clamp_d;
      fin.trunc   = phase_d != PH_DONE;
      fin.last    = 1'b1;
      if (tres_v && in_last_i) begin
        res_cnt_o = 2'd2;
        res0_o    = tres;
        res1_o    = fin;
      end else if (tres_v) begin
        res_cnt_o   = 2'd1;
        res0_o      = tres;
        res0_o.last = 1'b1;
      end else if (in_last_i) begin
        res_cnt_o = 2'd1;
        res0_o    = fin;
      end

      if (in_last_i) begin
        phase_d  = PH_HEADER;
        tcnt_d   = '0;
        in_tok_d = 1'b0;
        acc_d    = '0;
        sat_d    = 1'b0;
        ended_d  = 1'b0;
        name_d   = '0;
        nlen_d   = '0;
        chan_d   = tlgp_pkg::CH_UNKNOWN;
        eight_d  = 1'b0;
        chleft_d = '0;
        total_d  = '0;
        scnt_d   = '0;
        clamp_d  = 1'b0;
        excess_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      tcnt_q   <= '0;
      in_tok_q <= 1'b0;
      acc_q    <= '0;
      sat_q    <= 1'b0;
      ended_q  <= 1'b0;
      name_q   <= '0;
      nlen_q   <= '0;
      chan_q   <= tlgp_pkg::CH_UNKNOWN;
      eight_q  <= 1'b0;
      chleft_q <= '0;
      total_q  <= '0;
      scnt_q   <= '0;
      clamp_q  <= 1'b0;
      excess_q <= '0;
    end else begin
      phase_q  <= phase_d;
      tcnt_q   <= tcnt_d;
      in_tok_q <= in_tok_d;
      acc_q    <= acc_d;
      sat_q    <= sat_d;
      ended_q  <= ended_d;
      name_q   <= name_d;
      nlen_q   <= nlen_d;
      chan_q   <= chan_d;
      eight_q  <= eight_d;
      chleft_q <= chleft_d;
      total_q  <= total_d;
      scnt_q   <= scnt_d;
      clamp_q  <= clamp_d;
      excess_q <= excess_d;
    end
  end

endmodule

// ----- hw/rtl/tlgp_res_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlgp_res_fifo
// four-entry result queue, takes up to two results per cycle, gives one per cycle while the reader is ready
// ----------------------------------------------------------------------------
module tlgp_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         wr_cnt_i,
  input  tlgp_pkg::result_t  wr0_i,
  input  tlgp_pkg::result_t  wr1_i,
  output logic               room_o,
  output logic               rd_valid_o,
  input  logic               rd_ready_i,
  output tlgp_pkg::result_t  rd_data_o
);

  tlgp_pkg::result_t mem_q [4];
  logic [1:0]        wptr_q, wptr_d;
  logic [1:0]        rptr_q, rptr_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              rd;

  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_valid_o = cnt_q != 3'd0;
  assign rd_data_o  = mem_q[rptr_q];
  assign room_o     = cnt_q <= 3'd2;   // room for the two results of one item

  always_comb begin
    wptr_d = wptr_q + wr_cnt_i;
    rptr_d = rptr_q + {1'b0, rd};
    cnt_d  = cnt_q + {1'b0, wr_cnt_i} - {2'b00, rd};
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) mem_q[wptr_q] <= wr0_i;
    if (wr_cnt_i == 2'd2) mem_q[wptr_q + 2'd1] <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/laser_scan_telegram_parser.sv -----
`timescale 1ns / 1ps
// a result is queued as its byte is taken and can be offered from the cycle after
// throughput: one byte per cycle while the result queue has room; a byte that yields two
//   results (last sample or length plus the finished result) puts both into the result queue
// the slave side is held off only while the four-entry result queue has no room for two
// reset: asynchronous active low, parser returns to the header phase, queue empties
// ----------------------------------------------------------------------------
// laser_scan_telegram_parser
// byte-serial parser for the ascii scan data telegram of a laser range scanner
// ----------------------------------------------------------------------------
module laser_scan_telegram_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_telegram
  // result stream out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [10:0] sample_index, [42:11] sample_value, [54:43] channel_length,
  // [55] length_clamped, [56] truncated, [63:57] zero
  output logic [tlgp_pkg::TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] result_kind, [3:2] channel_type, [4] eight_bit_section
  output logic [tlgp_pkg::TUSER_W-1:0] m_axis_tuser_o,
  output logic        m_axis_tlast_o    // last_result
);

  logic              accept;
  logic              room;
  logic [1:0]        res_cnt;
  tlgp_pkg::result_t res0;
  tlgp_pkg::result_t res1;
  tlgp_pkg::result_t head;

  // a byte goes straight into the parse state; its results land in the queue
  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  tlgp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  // result queue parts the parser from a stalled consumer
  tlgp_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (res_cnt),
    .wr0_i      (res0),
    .wr1_i      (res1),
    .room_o     (room),
    .rd_valid_o (m_axis_tvalid_o),
    .rd_ready_i (m_axis_tready_i),
    .rd_data_o  (head)
  );

  // pack the head result onto the bus
  assign m_axis_tdata_o = {7'd0, head.trunc, head.clamped, head.len, head.value, head.idx};
  assign m_axis_tuser_o = {head.eight, head.chan, head.kind};
  assign m_axis_tlast_o = head.last;

endmodule

// ----- tb/laser_scan_telegram_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laser_scan_telegram_parser_tb
// drives ascii scan telegrams byte by byte into the parser and checks every
// result item against a cycle-free model of the telegram grammar kept in here;
// a short list of hand-written telegrams comes first, then random telegrams
// (mostly well formed, some cut short, some pure noise) under varying idling
// ----------------------------------------------------------------------------
module laser_scan_telegram_parser_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_BYTES  = 600;
  localparam int unsigned MAX_REPORTS = 10;

  // parser phases of the model
  typedef enum logic [3:0] {
    ST_HEADER, ST_ENC_COUNT, ST_ENC_SKIP, ST_CHAN_COUNT, ST_NAME, ST_SKIP4,
    ST_NSAMPLES, ST_SAMPLES, ST_DONE
  } scan_phase_e;

  // one row of the hand-written telegram list
  typedef struct {
    string             text;
    int unsigned       fill;    // number of generated sample tokens after text
    string             tail;
    bit                typed;   // closing result given below instead of modeled
    tlgp_pkg::result_t res;
  } telegram_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [tlgp_pkg::TDATA_W-1:0] m_axis_tdata_o;
  logic [tlgp_pkg::TUSER_W-1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  laser_scan_telegram_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // expected result items, oldest first
  tlgp_pkg::result_t expected_results[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // idling percentages of the current phase
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned src_pct_tab[4] = '{0, 49, 0, 38};
  int unsigned snk_pct_tab[4] = '{0, 0, 49, 38};

  // telegram under construction, the last byte carries tlast
  logic [7:0] telegram[$];
  telegram_row_t telegram_rows[$];

  // --------------------------------------------------------------------------
  // telegram model
  // --------------------------------------------------------------------------
  scan_phase_e phase;
  int unsigned tok_cnt;
  bit          in_tok;
  logic [31:0] acc;
  bit          acc_sat;
  bit          digits_done;
  logic [39:0] name_buf;
  int unsigned name_len;
  logic [2:0]  chan;
  bit          eight_sect;
  int unsigned chans_left;
  int unsigned smp_total;
  int unsigned smp_cnt;
  bit          clamp_seen;
  logic [31:0] excess_left;

  // results caused by the byte being modeled
  tlgp_pkg::result_t byte_res[2];
  int unsigned       byte_res_n;

  task automatic parser_reset();
    phase       = ST_HEADER;
    tok_cnt     = 0;
    in_tok      = 1'b0;
    acc         = '0;
    acc_sat     = 1'b0;
    digits_done = 1'b0;
    name_buf    = '0;
    name_len    = 0;
    chan        = tlgp_pkg::CH_UNKNOWN;
    eight_sect  = 1'b0;
    chans_left  = 0;
    smp_total   = 0;
    smp_cnt     = 0;
    clamp_seen  = 1'b0;
    excess_left = '0;
  endtask

  function automatic int unsigned sat255(input logic [31:0] v);
    return (v > 32'd255) ? 255 : int'(v);
  endfunction

  task automatic add_result(input tlgp_pkg::res_kind_e kind, input logic [10:0] idx,
                            input logic [31:0] value, input logic [11:0] len,
                            input logic trunc);
    tlgp_pkg::result_t r;
    r         = '0;
    r.kind    = kind;
    if (kind != tlgp_pkg::RES_FINISHED) begin
      r.chan  = chan[1:0];
      r.eight = eight_sect;
    end
    r.idx     = idx;
    r.value   = value;
    r.len     = len;
    r.clamped = clamp_seen;
    r.trunc   = trunc;
    byte_res[byte_res_n] = r;
    byte_res_n++;
  endtask

  // end of the 16-bit list moves on to the 8-bit list, end of that one is done
  task automatic section_done();
    if (!eight_sect) begin
      eight_sect = 1'b1;
      phase      = ST_CHAN_COUNT;
    end else begin
      phase = ST_DONE;
    end
  endtask

  task automatic channel_done();
    if (chans_left > 0) chans_left--;
    if (chans_left > 0) phase = ST_NAME;
    else section_done();
  endtask

  task automatic close_token();
    in_tok = 1'b0;
    case (phase)
      ST_HEADER: begin
        tok_cnt++;
        if (tok_cnt >= tlgp_pkg::HEADER_TOKENS) phase = ST_ENC_COUNT;
      end
      ST_ENC_COUNT: begin
        // two tokens per encoder follow the encoder count
        tok_cnt = 2 * sat255(acc);
        if (tok_cnt != 0) phase = ST_ENC_SKIP;
        else phase = ST_CHAN_COUNT;
      end
      ST_ENC_SKIP: begin
        if (tok_cnt > 0) tok_cnt--;
        if (tok_cnt == 0) phase = ST_CHAN_COUNT;
      end
      ST_CHAN_COUNT: begin
        chans_left = sat255(acc);
        if (chans_left != 0) phase = ST_NAME;
        else section_done();
      end
      ST_NAME: begin
        // only an exact five character name selects a channel
        chan = tlgp_pkg::CH_UNKNOWN;
        if (name_len == 5) begin
          for (int i = 0; i < 4; i++) begin
            if (name_buf == tlgp_pkg::CHAN_NAMES[i]) chan = 3'(i);
          end
        end
        tok_cnt = 4;
        phase   = ST_SKIP4;
      end
      ST_SKIP4: begin
        if (tok_cnt > 0) tok_cnt--;
        if (tok_cnt == 0) phase = ST_NSAMPLES;
      end
      ST_NSAMPLES: begin
        if (acc > 32'(tlgp_pkg::MAX_SAMPLES)) begin
          smp_total   = tlgp_pkg::MAX_SAMPLES;
          excess_left = acc - 32'(tlgp_pkg::MAX_SAMPLES);
          clamp_seen  = 1'b1;
        end else begin
          smp_total   = int'(acc);
          excess_left = '0;
        end
        smp_cnt = 0;
        if (chan != tlgp_pkg::CH_UNKNOWN)
          add_result(tlgp_pkg::RES_LENGTH, '0, '0, 12'(smp_total), 1'b0);
        if (acc == '0) channel_done();
        else phase = ST_SAMPLES;
      end
      ST_SAMPLES: begin
        if (smp_cnt < smp_total) begin
          if (chan != tlgp_pkg::CH_UNKNOWN)
            add_result(tlgp_pkg::RES_SAMPLE, 11'(smp_cnt), acc, 12'(smp_total), 1'b0);
          smp_cnt++;
        end else if (excess_left != '0) begin
          // samples past the store size are consumed silently
          excess_left--;
        end
        if (smp_cnt >= smp_total && excess_left == '0) channel_done();
      end
      default: begin
      end
    endcase
  endtask

  task automatic take_char(input logic [7:0] c);
    logic [63:0] wide;
    int unsigned base;
    int unsigned digit;
    if (!in_tok) begin
      in_tok      = 1'b1;
      acc         = '0;
      acc_sat     = 1'b0;
      digits_done = 1'b0;
      name_len    = 0;
      name_buf    = '0;
      if (c == tlgp_pkg::CHR_PLUS) return;
    end
    if (phase == ST_NAME) begin
      if (name_len < 5) begin
        name_buf = {name_buf[31:0], c};
        name_len++;
      end else begin
        name_len = 6;
      end
    end
    if (digits_done) return;
    base  = (phase == ST_NSAMPLES || phase == ST_SAMPLES) ? 16 : 10;
    digit = 16;
    if (c >= "0" && c <= "9") digit = c - "0";
    else if (base == 16 && c >= "A" && c <= "F") digit = c - "A" + 10;
    else if (base == 16 && c >= "a" && c <= "f") digit = c - "a" + 10;
    if (digit >= base) begin
      // first non-digit ends the number, rest of the token is ignored
      digits_done = 1'b1;
      return;
    end
    if (acc_sat) return;
    wide = {32'd0, acc} * 64'(base) + 64'(digit);
    if (wide > 64'hFFFF_FFFF) begin
      acc     = '1;
      acc_sat = 1'b1;
    end else begin
      acc = wide[31:0];
    end
  endtask

  // models one accepted byte and queues the result items it causes
  task automatic parse_byte(input logic [7:0] c, input bit eot);
    bit is_sep;
    byte_res_n = 0;
    is_sep = (c == tlgp_pkg::CHR_SPACE) || (c == tlgp_pkg::CHR_STX) ||
             (c == tlgp_pkg::CHR_ETX);
    if (is_sep) begin
      if (in_tok) close_token();
    end else begin
      take_char(c);
      if (eot) close_token();
    end
    if (eot) begin
      add_result(tlgp_pkg::RES_FINISHED, '0, '0, '0, phase != ST_DONE);
      parser_reset();
    end
    if (byte_res_n > 0) byte_res[byte_res_n-1].last = 1'b1;
    for (int i = 0; i < byte_res_n; i++) expected_results.push_back(byte_res[i]);
  endtask

  function automatic tlgp_pkg::result_t finished_res(input logic trunc);
    tlgp_pkg::result_t r;
    r       = '0;
    r.kind  = tlgp_pkg::RES_FINISHED;
    r.trunc = trunc;
    r.last  = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // telegram construction
  // --------------------------------------------------------------------------
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) telegram.push_back(s[i]);
  endtask

  // any byte that is not a separator, mostly printable
  function automatic logic [7:0] tok_char();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(8'h21, 8'h7E));
    do c = 8'($urandom_range(0, 255));
    while (c == tlgp_pkg::CHR_SPACE || c == tlgp_pkg::CHR_STX || c == tlgp_pkg::CHR_ETX);
    return c;
  endfunction

  task automatic add_gap();
    int unsigned r;
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(2, 4) : 1) begin
      r = $urandom_range(0, 9);
      if (r < 7) telegram.push_back(tlgp_pkg::CHR_SPACE);
      else if (r < 9) telegram.push_back(tlgp_pkg::CHR_STX);
      else telegram.push_back(tlgp_pkg::CHR_ETX);
    end
  endtask

  task automatic add_junk_token();
    repeat ($urandom_range(1, 6)) telegram.push_back(tok_char());
  endtask

  // decimal count, sometimes with a plus sign or a trailing token character
  task automatic add_dec(input int unsigned v);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) telegram.push_back(tlgp_pkg::CHR_PLUS);
    add_text($sformatf("%0d", v));
    if (r >= 90) telegram.push_back(tok_char());
  endtask

  // hex number in mixed case; unless plain it may carry a sign, extra digits
  // that may push it past 32 bits, or trailing garbage
  task automatic add_hex(input logic [31:0] v, input bit plain);
    string       s;
    string       hex_chars;
    int unsigned r;
    logic [7:0]  c;
    hex_chars = "0123456789abcdefABCDEF";
    s = $sformatf("%0h", v);
    r = plain ? 99 : $urandom_range(0, 99);
    if (r < 6) telegram.push_back(tlgp_pkg::CHR_PLUS);
    else if (r < 10) telegram.push_back("-");
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      telegram.push_back(c);
    end
    if (r >= 10 && r < 18) begin
      repeat ($urandom_range(1, 4)) telegram.push_back(hex_chars[$urandom_range(0, 21)]);
    end else if (r >= 18 && r < 24) begin
      telegram.push_back(tok_char());
    end
  endtask

  task automatic add_name();
    case ($urandom_range(0, 11))
      0, 1:    add_text("DIST1");
      2, 3:    add_text("DIST2");
      4, 5:    add_text("RSSI1");
      6, 7:    add_text("RSSI2");
      8:       add_text("DIST3");
      9:       add_text("RSSI12");
      10:      add_text("+RSSI1");
      default: add_junk_token();
    endcase
  endtask

  task automatic add_channel();
    int unsigned cnt;
    add_name();
    add_gap();
    repeat (4) begin
      add_junk_token();
      add_gap();
    end
    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    add_hex(32'(cnt), 1'b1);
    add_gap();
    repeat (cnt) begin
      add_hex($urandom() >> $urandom_range(0, 31), 1'b0);
      add_gap();
    end
  endtask

  task automatic build_scan();
    int unsigned enc;
    int unsigned r;
    int unsigned cut;
    telegram.delete();
    if ($urandom_range(0, 3) != 0) telegram.push_back(tlgp_pkg::CHR_STX);
    repeat (tlgp_pkg::HEADER_TOKENS) begin
      add_junk_token();
      add_gap();
    end
    enc = $urandom_range(0, 2);
    add_dec(enc);
    add_gap();
    repeat (2 * enc) begin
      add_junk_token();
      add_gap();
    end
    for (int sect = 0; sect < 2; sect++) begin
      r = $urandom_range(0, 3 - sect);
      add_dec(r);
      add_gap();
      repeat (r) add_channel();
    end
    // tokens after a complete telegram
    repeat ($urandom_range(0, 4) / 3) begin
      add_junk_token();
      add_gap();
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      telegram.push_back(tlgp_pkg::CHR_ETX);
    end else if (r < 85) begin
      // end flag on the last character of the last token
      while (telegram[$] == tlgp_pkg::CHR_SPACE || telegram[$] == tlgp_pkg::CHR_STX ||
             telegram[$] == tlgp_pkg::CHR_ETX)
        void'(telegram.pop_back());
    end else begin
      cut = $urandom_range(1, telegram.size());
      while (telegram.size() > cut) void'(telegram.pop_back());
    end
  endtask

  task automatic build_noise();
    telegram.delete();
    repeat ($urandom_range(1, 30)) telegram.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_row(input string text, input int unsigned fill, input string tail,
                         input bit typed, input tlgp_pkg::result_t res);
    telegram_row_t row;
    row.text  = text;
    row.fill  = fill;
    row.tail  = tail;
    row.typed = typed;
    row.res   = res;
    telegram_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // byte source
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit eot, input bit typed,
                           input tlgp_pkg::result_t res);
    int unsigned n_before;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eot;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    n_before = expected_results.size();
    parse_byte(b, eot);
    if (typed && eot) begin
      // closing result of a hand-checked row replaces the modeled one
      while (expected_results.size() > n_before) void'(expected_results.pop_back());
      expected_results.push_back(res);
    end
  endtask

  task automatic send_telegram(input bit typed, input tlgp_pkg::result_t res);
    for (int i = 0; i < telegram.size(); i++)
      send_byte(telegram[i], i == telegram.size() - 1, typed, res);
  endtask

  // --------------------------------------------------------------------------
  // result sink and checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    tlgp_pkg::result_t            e;
    logic [tlgp_pkg::TDATA_W-1:0] e_data;
    logic [tlgp_pkg::TUSER_W-1:0] e_user;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS)
          $display("unexpected result item: tdata %h tuser %h tlast %b",
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatch_cnt++;
      end else begin
        e      = expected_results.pop_front();
        e_data = {7'd0, e.trunc, e.clamped, e.len, e.value, e.idx};
        e_user = {e.eight, e.chan, e.kind};
        if (m_axis_tdata_o !== e_data || m_axis_tuser_o !== e_user ||
            m_axis_tlast_o !== e.last) begin
          if (mismatch_cnt < MAX_REPORTS)
            $display("result mismatch: expected tdata %h tuser %h tlast %b, got %h %h %b",
                     e_data, e_user, e.last, m_axis_tdata_o, m_axis_tuser_o,
                     m_axis_tlast_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    string         hdr;
    int unsigned   rand_bytes;
    int unsigned   mode;
    telegram_row_t row;

    parser_reset();
    // 18 header tokens of a typical telegram
    hdr = {"sRA LMDscandata 1 1 89A27F 0 0 343 347 27477BA9 2747813B",
           " 0 0 7 0 0 1388 168"};

    // lone end byte: nothing parsed, so the telegram is short
    add_row("\003", 0, "", 1'b1, finished_res(1'b1));
    // empty channel lists, later tokens ignored, etx inside as a separator
    add_row({"\002", hdr, " 0 0  0\003 DIST1 12\003"}, 0, "", 1'b1, finished_res(1'b0));
    // encoder skip, signs, hex prefixes, saturating sample
    add_row({"\002", hdr, " 1 F 0 +1 DIST1 3F800000 00000000 D9490 1B58 5 +1A 0x1F -3",
             " ffFF FFFFFFFFF 0\003"}, 0, "", 1'b0, '0);
    // both lists, unknown and long names, zero count ending on the last byte
    add_row({"\002", hdr, " 0 3 DIST2 a\377 b c d 2 1 2 DIST12 a b c d 2 5 6",
             " dist1 0 0 0 0 0 +2 RSSI1 0 0 0 0 1 FF RSSI2 1 2 3 4 0\003"},
            0, "", 1'b0, '0);
    // separator runs and lower case hex digits
    add_row({"\002\002  ", hdr, "  \003\002 0 1 RSSI1 q q q q +a 0 1 9 a f A F 10",
             " abcdef12 ABCDEF\003"}, 0, "", 1'b0, '0);
    // count beyond the store size on a telegram cut short
    add_row({"\002", hdr, " 0 1 RSSI2 0 0 0 0 FFFFFFFFFF 1 2 3\003"}, 0, "", 1'b0, '0);
    // run of generated samples filling the channel, then an empty 8-bit list
    add_row({"\002", hdr, " 0 1 DIST1 0 0 0 0 10 "}, 16, "0 \003", 1'b0, '0);
    // end flag on a sample character
    add_row({"\002", hdr, " 0 1 DIST1 0 0 0 0 3 7 8 9"}, 0, "", 1'b0, '0);
    // saturated encoder count, telegram ends long before the skip is done
    add_row({"\002", hdr, " +300 1 2 3\003"}, 0, "", 1'b1, finished_res(1'b1));
    // end flag on the last header character
    add_row({"\002", hdr}, 0, "", 1'b1, finished_res(1'b1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < telegram_rows.size(); i++) begin
      row           = telegram_rows[i];
      src_idle_pct  = src_pct_tab[i % 4];
      snk_stall_pct = snk_pct_tab[i % 4];
      telegram.delete();
      add_text(row.text);
      for (int k = 0; k < row.fill; k++) add_text($sformatf("%0h ", k * 40503));
      add_text(row.tail);
      send_telegram(row.typed, row.res);
    end

    // random telegrams, idling phase follows the share of bytes sent so far
    rand_bytes = 0;
    while (rand_bytes < RAND_BYTES) begin
      mode          = rand_bytes * 4 / RAND_BYTES;
      src_idle_pct  = src_pct_tab[mode];
      snk_stall_pct = snk_pct_tab[mode];
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_scan();
      send_telegram(1'b0, '0);
      rand_bytes += telegram.size();
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- laser_scan_telegram_parser.f -----
hw/rtl/tlgp_pkg.sv
hw/rtl/tlgp_core.sv
hw/rtl/tlgp_res_fifo.sv
hw/rtl/laser_scan_telegram_parser.sv
tb/laser_scan_telegram_parser_tb.sv
